FILE: rtl/tsdf_pkg.sv
// ----------------------------------------------------------------------------
// tsdf_pkg: shared definitions for the touch sample debounce filter
// Widths, plausibility limits, register indexes and reset values used by
// the top level and its submodules.
// ----------------------------------------------------------------------------
package tsdf_pkg;

  localparam int RAW_W          = 12;
  localparam int SIZE_W         = 13;
  localparam int JIT_W          = 12;
  localparam int OUT_W          = 12;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 3;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [RAW_W-1:0] RAW_LOW  = 12'd200;
  localparam logic [RAW_W-1:0] RAW_HIGH = 12'd3900;
  localparam logic [RAW_W-1:0] Z_LIMIT  = 12'd4000;

  localparam logic [1:0] PRESS_COUNT = 2'd2;
  localparam logic [1:0] FIRST_COUNT = 2'd1;

  localparam logic [RAW_W-1:0]  X_CAL_MIN_RST     = 12'd200;
  localparam logic [RAW_W-1:0]  X_CAL_MAX_RST     = 12'd3900;
  localparam logic [RAW_W-1:0]  Y_CAL_MIN_RST     = 12'd200;
  localparam logic [RAW_W-1:0]  Y_CAL_MAX_RST     = 12'd3900;
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 13'd240;
  localparam logic [JIT_W-1:0]  JITTER_LIMIT_RST  = 12'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_CAL_MIN     = 3'd0,
    REG_X_CAL_MAX     = 3'd1,
    REG_Y_CAL_MIN     = 3'd2,
    REG_Y_CAL_MAX     = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_JITTER_LIMIT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0]  lo;
    logic [RAW_W-1:0]  hi;
    logic [SIZE_W-1:0] size;
  } axis_cal_t;

endpackage

FILE: rtl/tsdf_map_unit.sv
// ----------------------------------------------------------------------------
// tsdf_map_unit: serial calibration mapping for one axis
// Forms (raw - lo) * (size - 1) with a bit-serial shift-add multiplier, then
// divides by (hi - lo) with a restoring divider, one quotient bit per cycle, and inverts the axis.
// ----------------------------------------------------------------------------
module tsdf_map_unit import tsdf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RAW_W-1:0]      raw,
  input  axis_cal_t             cal,
  output logic                  done,
  output logic [COORD_BITS-1:0] value
);

  localparam int PW    = RAW_W + COORD_BITS;
  localparam int CNT_W = $clog2(PW + 1);
  localparam int CMP_W = (SIZE_W > COORD_BITS + 1) ? SIZE_W : COORD_BITS + 1;
  localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'(1) << COORD_BITS;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_DIV  = 4'b0100,
    M_FIN  = 4'b1000
  } map_state_t;

  map_state_t            state;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] top;
  logic [COORD_BITS-1:0] mplier;
  logic [RAW_W-1:0]      off;
  logic [RAW_W-1:0]      dvsr;
  logic [PW-1:0]         acc;
  logic [RAW_W-1:0]      rem;
  logic                  bad_cal;
  logic                  below;

  logic [CMP_W-1:0]      size_ext;
  logic [COORD_BITS-1:0] top_start;
  logic [PW-1:0]         acc_add;
  logic [RAW_W:0]        trial;
  logic [RAW_W:0]        trial_sub;
  logic                  fits;
  logic [RAW_W-1:0]      rem_next;
  logic [COORD_BITS-1:0] mapped;

  // The screen size is clamped to 1..2^COORD_BITS before the top coordinate is taken.
  always_comb begin
    size_ext = CMP_W'(cal.size);
    if (size_ext == '0) begin
      top_start = '0;
    end else if (size_ext > SIZE_CAP) begin
      top_start = '1;
    end else begin
      top_start = COORD_BITS'(size_ext - CMP_W'(1));
    end
  end

  always_comb begin
    acc_add   = {acc[PW-2:0], 1'b0} + (mplier[COORD_BITS-1] ? PW'(off) : '0);
    trial     = {rem, acc[PW-1]};
    fits      = trial >= {1'b0, dvsr};
    trial_sub = trial - {1'b0, dvsr};
    rem_next  = fits ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
  end

  // A sample left of the low bound lands beyond the top and clamps to it; a
  // quotient above the top clamps to zero.
  always_comb begin
    if (bad_cal) begin
      mapped = '0;
    end else if (below) begin
      mapped = top;
    end else if (acc > PW'(top)) begin
      mapped = '0;
    end else begin
      mapped = top - acc[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          if (start) begin
            state <= M_MUL;
            cnt   <= CNT_W'(COORD_BITS - 1);
          end
        end
        M_MUL: begin
          if (cnt == '0) begin
            state <= M_DIV;
            cnt   <= CNT_W'(PW - 1);
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        M_DIV: begin
          if (cnt == '0) begin
            state <= M_FIN;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        M_FIN: begin
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (start) begin
          top     <= top_start;
          mplier  <= top_start;
          off     <= raw - cal.lo;
          dvsr    <= cal.hi - cal.lo;
          acc     <= '0;
          rem     <= '0;
          bad_cal <= cal.hi <= cal.lo;
          below   <= raw < cal.lo;
        end
      end
      M_MUL: begin
        acc    <= acc_add;
        mplier <= {mplier[COORD_BITS-2:0], 1'b0};
      end
      M_DIV: begin
        acc <= {acc[PW-2:0], fits};
        rem <= rem_next;
      end
      M_FIN: begin
        value <= mapped;
      end
      default: begin
      end
    endcase
  end

  assign done = (state == M_FIN);

endmodule

FILE: rtl/tsdf_track.sv
// ----------------------------------------------------------------------------
// tsdf_track: press detection and position smoothing
// Holds the press state and the smoothed position, and forms the result
// registers for each finished sample.
// ----------------------------------------------------------------------------
module tsdf_track import tsdf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  reject,
  input  logic [COORD_BITS-1:0] map_x,
  input  logic [COORD_BITS-1:0] map_y,
  input  logic [JIT_W-1:0]      jitter,
  output logic                  pressed,
  output logic [OUT_W-1:0]      point_x,
  output logic [OUT_W-1:0]      point_y
);

  localparam int DW = (JIT_W > COORD_BITS) ? JIT_W : COORD_BITS;

  logic                  press_flag;
  logic [1:0]            stable_count;
  logic [COORD_BITS-1:0] held_x;
  logic [COORD_BITS-1:0] held_y;

  logic                  press_flag_next;
  logic [1:0]            stable_count_next;
  logic [COORD_BITS-1:0] held_x_next;
  logic [COORD_BITS-1:0] held_y_next;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  near;
  logic [COORD_BITS:0]   sum_x;
  logic [COORD_BITS:0]   sum_y;

  always_comb begin
    dx    = (map_x >= held_x) ? map_x - held_x : held_x - map_x;
    dy    = (map_y >= held_y) ? map_y - held_y : held_y - map_y;
    near  = (stable_count != '0) && (DW'(dx) <= DW'(jitter)) && (DW'(dy) <= DW'(jitter));
    sum_x = {1'b0, held_x} + {1'b0, map_x};
    sum_y = {1'b0, held_y} + {1'b0, map_y};

    press_flag_next   = press_flag;
    stable_count_next = stable_count;
    held_x_next       = held_x;
    held_y_next       = held_y;
    if (reject) begin
      press_flag_next   = 1'b0;
      stable_count_next = '0;
    end else if (!press_flag) begin
      held_x_next = map_x;
      held_y_next = map_y;
      if (near) begin
        press_flag_next   = 1'b1;
        stable_count_next = PRESS_COUNT;
      end else begin
        stable_count_next = FIRST_COUNT;
      end
    end else begin
      held_x_next = sum_x[COORD_BITS:1];
      held_y_next = sum_y[COORD_BITS:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_flag   <= 1'b0;
      stable_count <= '0;
      held_x       <= '0;
      held_y       <= '0;
    end else if (load) begin
      press_flag   <= press_flag_next;
      stable_count <= stable_count_next;
      held_x       <= held_x_next;
      held_y       <= held_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pressed <= press_flag_next;
      point_x <= press_flag_next ? OUT_W'(held_x_next) : '0;
      point_y <= press_flag_next ? OUT_W'(held_y_next) : '0;
    end
  end

endmodule

FILE: rtl/touch_sample_debounce_filter_top.sv
// ----------------------------------------------------------------------------
// touch_sample_debounce_filter_top: touch debounce and smoothing filter
// Maps raw touch samples to screen coordinates, debounces the press and
// smooths the held position.
// ----------------------------------------------------------------------------
// Each input transaction carries one poll of the touch controller: the
// contact flag and raw x, y and pressure readings. Each poll gives exactly
// one output transaction with the press state and the screen position.
// Both channels use valid and stall; a transaction moves on a rising edge
// where valid is high and stall is low.
// A plausible sample runs through two serial mapping units, one per axis,
// side by side. Each runs a shift-add multiply and then a restoring divide,
// and the input stays stalled until both units are done and the result is
// loaded into the output register, so a new sample is taken only after the
// last one has left. A rejected sample skips the mapping units and goes
// straight to the final state, where it waits for the output register.
// The output is a register: a new sample is taken while an older result
// waits on a stalled receiver, and that sample finishes once the register
// frees. Reset releases the touch, clears the debounce count and loads the
// default calibration. Configuration writes are taken at any time and must
// only be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module touch_sample_debounce_filter_top import tsdf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  touched,
  input  logic [RAW_W-1:0]      raw_x,
  input  logic [RAW_W-1:0]      raw_y,
  input  logic [RAW_W-1:0]      raw_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  pressed,
  output logic [OUT_W-1:0]      point_x,
  output logic [OUT_W-1:0]      point_y,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAP  = 3'b010,
    S_FIN  = 3'b100
  } top_state_t;

  top_state_t            state;
  axis_cal_t             x_cal;
  axis_cal_t             y_cal;
  logic [JIT_W-1:0]      jitter_limit;
  logic                  rej;

  logic                  accept;
  logic                  reject;
  logic                  start;
  logic                  out_free;
  logic                  load;
  logic                  x_done;
  logic                  y_done;
  logic [COORD_BITS-1:0] map_x;
  logic [COORD_BITS-1:0] map_y;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign reject   = !touched || ((raw_x == '0) && (raw_y == '0)) || (raw_z >= Z_LIMIT) ||
                    (raw_x < RAW_LOW) || (raw_x > RAW_HIGH) ||
                    (raw_y < RAW_LOW) || (raw_y > RAW_HIGH);
  assign start    = accept && !reject;
  assign out_free = !out_valid || !out_stall;
  assign load     = (state == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cal        <= '{lo: X_CAL_MIN_RST, hi: X_CAL_MAX_RST, size: SCREEN_WIDTH_RST};
      y_cal        <= '{lo: Y_CAL_MIN_RST, hi: Y_CAL_MAX_RST, size: SCREEN_HEIGHT_RST};
      jitter_limit <= JITTER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_CAL_MIN:     x_cal.lo     <= cfg_data[RAW_W-1:0];
        REG_X_CAL_MAX:     x_cal.hi     <= cfg_data[RAW_W-1:0];
        REG_Y_CAL_MIN:     y_cal.lo     <= cfg_data[RAW_W-1:0];
        REG_Y_CAL_MAX:     y_cal.hi     <= cfg_data[RAW_W-1:0];
        REG_SCREEN_WIDTH:  x_cal.size   <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: y_cal.size   <= cfg_data[SIZE_W-1:0];
        REG_JITTER_LIMIT:  jitter_limit <= cfg_data[JIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rej       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rej   <= reject;
            state <= reject ? S_FIN : S_MAP;
          end
        end
        S_MAP: begin
          if (x_done && y_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  tsdf_map_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_map_x (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (raw_x),
    .cal   (x_cal),
    .done  (x_done),
    .value (map_x)
  );

  tsdf_map_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_map_y (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (raw_y),
    .cal   (y_cal),
    .done  (y_done),
    .value (map_y)
  );

  tsdf_track #(
    .COORD_BITS(COORD_BITS)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .reject  (rej),
    .map_x   (map_x),
    .map_y   (map_y),
    .jitter  (jitter_limit),
    .pressed (pressed),
    .point_x (point_x),
    .point_y (point_y)
  );

endmodule

FILE: rtl/tsdf_checker.sv
// ----------------------------------------------------------------------------
// tsdf_checker: port-level checks for the touch debounce filter
// Watches the channels of the top level and flags results that break its
// sequencing or its released-result rule.
// ----------------------------------------------------------------------------
module tsdf_checker import tsdf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             touched,
  input logic             out_valid,
  input logic             out_stall,
  input logic             pressed,
  input logic [OUT_W-1:0] point_x,
  input logic [OUT_W-1:0] point_y
);

  // A stalled result keeps its transaction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressed) &&
                               $stable(point_x) && $stable(point_y))
    else $error("stalled output transaction changed");

  // A released result reports the origin.
  a_released_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressed |-> (point_x == '0) && (point_y == '0))
    else $error("released result with a nonzero point");

  // Only one sample is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample was in work");

  // A poll without contact, taken while the output is empty, gives a released result.
  a_no_touch_release: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !touched && !out_valid |-> ##2 (out_valid && !pressed))
    else $error("poll without contact did not give a released result");

  // Reset empties the output and opens the input.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

endmodule

bind touch_sample_debounce_filter_top tsdf_checker u_tsdf_checker (.*);
